[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL that checks its own invariants.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/spnwl_pkg.sv]
// Shared types and constants of the Star+ wirelength block.
`timescale 1ns / 1ps
package spnwl_pkg;
  localparam int COORD_W   = 16;
  localparam int LEN_W     = 32;
  localparam int TOTAL_W   = 48;
  localparam int PINS_W    = 9;
  localparam int ALPHA_W   = 10;
  localparam int BETA_W    = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 10'd256;
  localparam logic [BETA_W-1:0]  BETA_RESET  = 16'd407;
  // register index, taken from paddr[2]
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_KQ,
    ST_MUL_SS,
    ST_DIV,
    ST_SQRT,
    ST_SCALE,
    ST_SUM,
    ST_OUT
  } back_state_e;
endpackage

[rtl/core/star_plus_net_wirelength.sv]
// Pins: one transaction per cycle when the net queue has room; the front adds each pin at once.
// Per net, the back end runs a bit-serial multiply, divide and square root, shared by both axes,
// and takes no new net until the last one's result is in the output register.
// Two closed nets queue ahead of the back end; one finished result waits in the output register.
// Reset (async, active low) clears the accumulators, the running total and the queue;
// alpha_gain returns to 1.0 and beta_offset to 1.59.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module star_plus_net_wirelength import spnwl_pkg::*; #(
  parameter int MAX_PINS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pin_x[15:0], pin_y[31:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // net_length[31:0], running_total[79:32], pin_total[88:80], zero pad
  output logic        m_tuser,   // pin_overflow[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int KW   = $clog2(MAX_PINS + 1);
  localparam int SW   = COORD_W + KW;
  localparam int QW   = 2 * COORD_W + KW;
  localparam int RECW = 1 + 2 * QW + 2 * SW + KW;

  logic [ALPHA_W-1:0] alpha_q;
  logic [BETA_W-1:0]  beta_q;
  logic               acc_in, push, pop, full, empty;
  logic [RECW-1:0]    rec_w, rec_r;
  logic [LEN_W-1:0]   len;
  logic [TOTAL_W-1:0] total;
  logic [PINS_W-1:0]  pins;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      beta_q  <= BETA_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ALPHA: alpha_q <= pwdata[ALPHA_W-1:0];
        REG_BETA:  beta_q  <= pwdata[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ALPHA: prdata = 32'(alpha_q);
      REG_BETA:  prdata = 32'(beta_q);
      default:   prdata = '0;
    endcase
  end

  assign s_tready = ~full;
  assign acc_in   = s_tvalid & s_tready;

  spnwl_front #(
    .MAX_PINS(MAX_PINS), .KW(KW), .SW(SW), .QW(QW), .RECW(RECW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(acc_in),
    .last_i (s_tlast),
    .x_i    (s_tdata[15:0]),
    .y_i    (s_tdata[31:16]),
    .push_o (push),
    .rec_o  (rec_w)
  );

  spnwl_fifo #(.WIDTH(RECW)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(rec_w),
    .pop_i  (pop),
    .rdata_o(rec_r),
    .full_o (full),
    .empty_o(empty)
  );

  spnwl_back #(.KW(KW), .SW(SW), .QW(QW), .RECW(RECW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alpha_i    (alpha_q),
    .beta_i     (beta_q),
    .rec_valid_i(~empty),
    .rec_i      (rec_r),
    .pop_o      (pop),
    .valid_o    (m_tvalid),
    .ready_i    (m_tready),
    .len_o      (len),
    .total_o    (total),
    .pins_o     (pins),
    .ovf_o      (m_tuser)
  );

  assign m_tdata = {7'b0, pins, total, len};

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push && full)
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && empty)
  `ASSERT_IMPLY(a_total_covers_len, clk_i, rst_ni, m_tvalid, total >= TOTAL_W'(len))
endmodule

[rtl/core/spnwl_front.sv]
// Front end: accumulates pin count, sums and sums of squares per net.
`timescale 1ns / 1ps
module spnwl_front import spnwl_pkg::*; #(
  parameter int MAX_PINS = 256,
  parameter int KW       = 9,
  parameter int SW       = 25,
  parameter int QW       = 41,
  parameter int RECW     = 1 + 2 * 41 + 2 * 25 + 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               last_i,
  input  logic [COORD_W-1:0] x_i,
  input  logic [COORD_W-1:0] y_i,
  output logic               push_o,
  output logic [RECW-1:0]    rec_o
);
  logic [KW-1:0] cnt_q, cnt_d, cnt_n;
  logic [SW-1:0] sx_q, sx_d, sx_n, sy_q, sy_d, sy_n;
  logic [QW-1:0] qx_q, qx_d, qx_n, qy_q, qy_d, qy_n;
  logic          ovf_q, ovf_d, ovf_n;
  logic          room;
  logic [2*COORD_W-1:0] xsq, ysq;

  assign room = cnt_q < KW'(MAX_PINS);
  assign xsq  = x_i * x_i;
  assign ysq  = y_i * y_i;

  always_comb begin
    cnt_n = room ? cnt_q + KW'(1) : cnt_q;
    sx_n  = room ? sx_q + SW'(x_i) : sx_q;
    sy_n  = room ? sy_q + SW'(y_i) : sy_q;
    qx_n  = room ? qx_q + QW'(xsq) : qx_q;
    qy_n  = room ? qy_q + QW'(ysq) : qy_q;
    ovf_n = ovf_q | ~room;
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    qx_d  = qx_q;
    qy_d  = qy_q;
    ovf_d = ovf_q;
    if (valid_i) begin
      if (last_i) begin
        // net closed: clear for the next one
        cnt_d = '0;
        sx_d  = '0;
        sy_d  = '0;
        qx_d  = '0;
        qy_d  = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_n;
        sx_d  = sx_n;
        sy_d  = sy_n;
        qx_d  = qx_n;
        qy_d  = qy_n;
        ovf_d = ovf_n;
      end
    end
  end

  assign push_o = valid_i & last_i;
  assign rec_o  = {ovf_n, qy_n, qx_n, sy_n, sx_n, cnt_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      qx_q  <= '0;
      qy_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      qx_q  <= qx_d;
      qy_q  <= qy_d;
      ovf_q <= ovf_d;
    end
  end
endmodule

[rtl/core/spnwl_fifo.sv]
// Two-entry queue of closed nets between the front and back ends.
`timescale 1ns / 1ps
module spnwl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

[rtl/core/spnwl_back.sv]
// Back end: per-net variance, root and scaling on shared serial units.
`timescale 1ns / 1ps
module spnwl_back import spnwl_pkg::*; #(
  parameter int KW   = 9,
  parameter int SW   = 25,
  parameter int QW   = 41,
  parameter int RECW = 1 + 2 * 41 + 2 * 25 + 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ALPHA_W-1:0] alpha_i,
  input  logic [BETA_W-1:0]  beta_i,
  input  logic               rec_valid_i,
  input  logic [RECW-1:0]    rec_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [LEN_W-1:0]   len_o,
  output logic [TOTAL_W-1:0] total_o,
  output logic [PINS_W-1:0]  pins_o,
  output logic               ovf_o
);
  localparam int PW   = KW + QW;
  localparam int DW   = PW + 16;
  localparam int RW   = DW + 2;
  localparam int HW   = RW / 2;
  localparam int SRW  = HW + 3;
  localparam int AXW  = HW + 2;
  localparam int SUMW = (AXW + 1 > LEN_W + 1) ? AXW + 1 : LEN_W + 1;
  localparam int CW   = $clog2(DW + 1);

  back_state_e state_q, state_d;
  logic [KW-1:0]  k_q, k_d;
  logic [SW-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [QW-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic           rovf_q, rovf_d;
  logic           axis_q, axis_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [PW-1:0]  mul_a_q, mul_a_d, acc_q, acc_d, prod_q, prod_d;
  logic [SW-1:0]  mul_b_q, mul_b_d;
  logic [DW-1:0]  dvd_q, dvd_d;
  logic [KW-1:0]  rem_q, rem_d;
  logic [RW-1:0]  rad_q, rad_d;
  logic [HW-1:0]  root_q, root_d;
  logic [SRW-1:0] srem_q, srem_d;
  logic [AXW-1:0] ax0_q, ax0_d, ax1_q, ax1_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               valid_q, valid_d;
  logic [LEN_W-1:0]   olen_q, olen_d;
  logic [PINS_W-1:0]  pins_q, pins_d;
  logic               ovf_q, ovf_d;

  logic [KW-1:0] rk;
  logic [SW-1:0] rsx, rsy;
  logic [QW-1:0] rqx, rqy;
  logic          rovf;
  logic [SW-1:0] s_sel;
  logic [QW-1:0] q_sel;
  logic [PW-1:0] acc_step, vdiff;
  logic [KW:0]   rem_sh, rem_sub;
  logic          dge;
  logic [SRW-1:0] srem_sh, trial;
  logic           sge;
  logic [HW+ALPHA_W-1:0] scaled;
  logic [SUMW-1:0] sum_w;
  logic [TOTAL_W:0] tot_w;

  assign {rovf, rqy, rqx, rsy, rsx, rk} = rec_i;
  assign s_sel    = axis_q ? sy_q : sx_q;
  assign q_sel    = axis_q ? qy_q : qx_q;
  assign acc_step = mul_b_q[0] ? acc_q + mul_a_q : acc_q;
  assign vdiff    = (prod_q > acc_step) ? prod_q - acc_step : '0;
  assign rem_sh   = {rem_q, dvd_q[DW-1]};
  // zero pins would divide by zero; the numerator is zero then as well
  assign dge      = (k_q != '0) && (rem_sh >= {1'b0, k_q});
  assign rem_sub  = dge ? rem_sh - {1'b0, k_q} : rem_sh;
  assign srem_sh  = {srem_q[SRW-3:0], rad_q[RW-1:RW-2]};
  assign trial    = SRW'({root_q, 2'b01});
  assign sge      = srem_sh >= trial;
  assign scaled   = root_q * alpha_i;
  assign sum_w    = SUMW'(ax0_q) + SUMW'(ax1_q);
  assign tot_w    = {1'b0, total_q} + (TOTAL_W + 1)'(len_q);

  always_comb begin
    state_d = state_q;
    k_d = k_q; sx_d = sx_q; sy_d = sy_q; qx_d = qx_q; qy_d = qy_q;
    rovf_d = rovf_q;
    axis_d = axis_q;
    cnt_d = cnt_q;
    mul_a_d = mul_a_q; mul_b_d = mul_b_q; acc_d = acc_q; prod_d = prod_q;
    dvd_d = dvd_q; rem_d = rem_q;
    rad_d = rad_q; root_d = root_q; srem_d = srem_q;
    ax0_d = ax0_q; ax1_d = ax1_q;
    len_d = len_q; total_d = total_q;
    valid_d = valid_q & ~ready_i;
    olen_d = olen_q; pins_d = pins_q; ovf_d = ovf_q;
    pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (rec_valid_i) begin
          pop_o = 1'b1;
          k_d = rk; sx_d = rsx; sy_d = rsy; qx_d = rqx; qy_d = rqy;
          rovf_d = rovf;
          axis_d = 1'b0;
          mul_a_d = PW'(rqx);
          mul_b_d = SW'(rk);
          acc_d = '0;
          cnt_d = CW'(KW);
          state_d = ST_MUL_KQ;
        end
      end
      ST_MUL_KQ: begin
        acc_d = acc_step;
        mul_a_d = mul_a_q << 1;
        mul_b_d = mul_b_q >> 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          prod_d = acc_step;
          mul_a_d = PW'(s_sel);
          mul_b_d = s_sel;
          acc_d = '0;
          cnt_d = CW'(SW);
          state_d = ST_MUL_SS;
        end
      end
      ST_MUL_SS: begin
        acc_d = acc_step;
        mul_a_d = mul_a_q << 1;
        mul_b_d = mul_b_q >> 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          // scaled by 2^16 so the quotient carries the fraction bits
          dvd_d = {vdiff, 16'b0};
          rem_d = '0;
          cnt_d = CW'(DW);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_sub[KW-1:0];
        dvd_d = {dvd_q[DW-2:0], dge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          rad_d = RW'({dvd_q[DW-2:0], dge}) + RW'({beta_i, 8'b0});
          root_d = '0;
          srem_d = '0;
          cnt_d = CW'(HW);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_d = sge ? srem_sh - trial : srem_sh;
        root_d = {root_q[HW-2:0], sge};
        rad_d = rad_q << 2;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (axis_q) begin
          ax1_d = scaled[HW+ALPHA_W-1:8];
          state_d = ST_SUM;
        end else begin
          ax0_d = scaled[HW+ALPHA_W-1:8];
          axis_d = 1'b1;
          mul_a_d = PW'(qy_q);
          mul_b_d = SW'(k_q);
          acc_d = '0;
          cnt_d = CW'(KW);
          state_d = ST_MUL_KQ;
        end
      end
      ST_SUM: begin
        len_d = (sum_w > SUMW'(33'h0FFFFFFFF)) ? '1 : sum_w[LEN_W-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!valid_q || ready_i) begin
          total_d = tot_w[TOTAL_W] ? '1 : tot_w[TOTAL_W-1:0];
          olen_d = len_q;
          pins_d = PINS_W'(k_q);
          ovf_d = rovf_q;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; sx_q <= sx_d; sy_q <= sy_d; qx_q <= qx_d; qy_q <= qy_d;
    rovf_q <= rovf_d;
    axis_q <= axis_d;
    cnt_q <= cnt_d;
    mul_a_q <= mul_a_d; mul_b_q <= mul_b_d; acc_q <= acc_d; prod_q <= prod_d;
    dvd_q <= dvd_d; rem_q <= rem_d;
    rad_q <= rad_d; root_q <= root_d; srem_q <= srem_d;
    ax0_q <= ax0_d; ax1_q <= ax1_d;
    len_q <= len_d;
    olen_q <= olen_d; pins_q <= pins_d; ovf_q <= ovf_d;
  end

  assign valid_o = valid_q;
  assign len_o   = olen_q;
  assign total_o = total_q;
  assign pins_o  = pins_q;
  assign ovf_o   = ovf_q;
endmodule

[dv/star_plus_net_wirelength_tb.sv]
// Self-checking testbench for the Star+ net wirelength block.
`timescale 1ns / 1ps
module star_plus_net_wirelength_tb;
  import spnwl_pkg::*;

  localparam int NET_PINS_MAX = 256;
  localparam int BACK_END_WAIT = 400;

  typedef struct packed {
    logic [LEN_W-1:0]   net_len;
    logic [TOTAL_W-1:0] total;
    logic [PINS_W-1:0]  pins;
    logic               ovf;
  } net_result_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               typed;
    logic [LEN_W-1:0]   len;
  } pin_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  star_plus_net_wirelength dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the block's state
  logic [ALPHA_W-1:0] alpha_m;
  logic [BETA_W-1:0]  beta_m;
  int unsigned        pins_m;
  longint unsigned    sx_m, sy_m, qx_m, qy_m, total_m;
  logic               ovf_m;

  net_result_t net_expect_q[$];
  int          fail_cnt = 0;
  bit          quiet_mode = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd4294967296;
    // largest r with r*r <= v
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    r = lo;
    return r;
  endfunction

  function automatic longint unsigned axis_len(longint unsigned k, longint unsigned s,
                                               longint unsigned q);
    longint unsigned v;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned rad;
    v = 0;
    whole = 0;
    frac = 0;
    if (k != 0) begin
      v = (k * q > s * s) ? k * q - s * s : 0;
      whole = v / k;
      frac = ((v % k) << 16) / k;
    end
    rad = (whole << 16) + frac + (longint'(beta_m) << 8);
    return (int_sqrt(rad) * alpha_m) >> 8;
  endfunction

  // update the mirror with one pin; queue a result when the net closes
  task automatic predict_pin(input logic [15:0] x, input logic [15:0] y, input logic last,
                             input logic typed, input logic [LEN_W-1:0] typed_len);
    longint unsigned len;
    net_result_t     res;
    if (pins_m < NET_PINS_MAX) begin
      sx_m += x;
      sy_m += y;
      qx_m += longint'(x) * x;
      qy_m += longint'(y) * y;
      pins_m++;
    end else begin
      ovf_m = 1'b1;
    end
    if (last) begin
      len = axis_len(pins_m, sx_m, qx_m) + axis_len(pins_m, sy_m, qy_m);
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
      total_m += len;
      if (total_m > 64'hFFFF_FFFF_FFFF) total_m = 64'hFFFF_FFFF_FFFF;
      res.net_len = typed ? typed_len : len[LEN_W-1:0];
      res.total = total_m[TOTAL_W-1:0];
      res.pins = pins_m[PINS_W-1:0];
      res.ovf = ovf_m;
      net_expect_q = {net_expect_q, res};
      pins_m = 0;
      sx_m = 0;
      sy_m = 0;
      qx_m = 0;
      qy_m = 0;
      ovf_m = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pin(input logic [15:0] x, input logic [15:0] y, input logic last,
                          input logic typed = 1'b0, input logic [LEN_W-1:0] typed_len = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata = {y, x};
    s_tlast = last;
    do @(posedge clk_i); while (!s_tready);
    predict_pin(x, y, last, typed, typed_len);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_regs(input logic [ALPHA_W-1:0] a, input logic [BETA_W-1:0] b);
    // drain the back end before touching the registers
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (net_expect_q.size() != 0) @(posedge clk_i);
    repeat (BACK_END_WAIT) @(posedge clk_i);
    apb_write({REG_ALPHA, 2'b00}, {$urandom} << ALPHA_W | a);
    apb_write({REG_BETA, 2'b00}, {$urandom} << BETA_W | b);
    alpha_m = a;
    beta_m = b;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_nets(input int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      quiet_mode = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) len = $urandom_range(9, 40);
      else len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_pin(pick_coord(), pick_coord(), i == len - 1);
      sent += len;
    end
  endtask

  // sink side backpressure
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 99) < 25)
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    net_result_t want;
    net_result_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.net_len = m_tdata[31:0];
      got.total = m_tdata[79:32];
      got.pins = m_tdata[88:80];
      got.ovf = m_tuser;
      if (net_expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = net_expect_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  pin_row_t pin_rows[] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 32'd644},   // single pin: alpha*sqrt(beta) per axis
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd644},
    '{16'd12345, 16'd54321, 1'b1, 1'b1, 32'd644},
    '{16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 32'd644},   // coincident pins: zero spread
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 32'd0},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b0, 32'd0},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, 32'd0},
    '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 32'd0},
    '{16'd1, 16'd2, 1'b0, 1'b0, 32'd0},
    '{16'd3, 16'd4, 1'b0, 1'b0, 32'd0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'd0},
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 32'd0},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 32'd0},
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 32'd0},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b0, 32'd0}
  };

  initial begin
    alpha_m = ALPHA_RESET;
    beta_m = BETA_RESET;
    pins_m = 0;
    sx_m = 0;
    sy_m = 0;
    qx_m = 0;
    qy_m = 0;
    total_m = 0;
    ovf_m = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (pin_rows[i])
      send_pin(pin_rows[i].x, pin_rows[i].y, pin_rows[i].last, pin_rows[i].typed,
               pin_rows[i].len);
    // full net without overflow, then three past the pin limit
    for (int i = 0; i < NET_PINS_MAX; i++)
      send_pin(pick_coord(), pick_coord(), i == NET_PINS_MAX - 1);
    for (int i = 0; i < NET_PINS_MAX + 3; i++)
      send_pin(pick_coord(), pick_coord(), i == NET_PINS_MAX + 2);

    random_nets(40);
    set_regs('0, '0);
    send_pin(16'd100, 16'd200, 1'b1, 1'b1, 32'd0);   // alpha zero: no length
    random_nets(20);
    set_regs({ALPHA_W{1'b1}}, {BETA_W{1'b1}});
    random_nets(20);
    set_regs({ALPHA_W{1'b1}}, '0);
    random_nets(20);
    set_regs('0, {BETA_W{1'b1}});
    random_nets(15);
    set_regs(ALPHA_W'($urandom), BETA_W'($urandom));
    random_nets(20);
    set_regs(ALPHA_RESET, BETA_RESET);
    random_nets(20);

    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (net_expect_q.size() != 0) @(posedge clk_i);
    repeat (BACK_END_WAIT) @(posedge clk_i);
    if (fail_cnt == 0 && net_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[star_plus_net_wirelength.f]
+incdir+rtl/core
rtl/core/spnwl_pkg.sv
rtl/core/spnwl_front.sv
rtl/core/spnwl_fifo.sv
rtl/core/spnwl_back.sv
rtl/core/star_plus_net_wirelength.sv
dv/star_plus_net_wirelength_tb.sv
